// ===== rtl/ssp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ssp_pkg
// shared widths, register indexes and control types for the soft-start
// phase-angle controller
// ----------------------------------------------------------------------------
package ssp_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int DELAY_BITS  = 20;
    localparam int SQ_BITS     = 2 * SAMPLE_BITS;
    localparam int SUM_BITS    = 32;
    localparam int WIN_BITS    = 8;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 32;

    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_OFFSET        = 3'd0;
    localparam t_cfg_idx CFG_WINDOW_LENGTH = 3'd1;
    localparam t_cfg_idx CFG_ON_THRESHOLD  = 3'd2;
    localparam t_cfg_idx CFG_OFF_THRESHOLD = 3'd3;
    localparam t_cfg_idx CFG_RAMP_START    = 3'd4;
    localparam t_cfg_idx CFG_RAMP_STEP     = 3'd5;
    localparam t_cfg_idx CFG_ON_TIME       = 3'd6;

    localparam logic [SAMPLE_BITS-1:0] RST_OFFSET        = SAMPLE_BITS'(1985);
    localparam logic [WIN_BITS-1:0]    RST_WINDOW_LENGTH = WIN_BITS'(200);
    localparam logic [SUM_BITS-1:0]    RST_ON_THRESHOLD  = SUM_BITS'(257322800);
    localparam logic [SUM_BITS-1:0]    RST_OFF_THRESHOLD = SUM_BITS'(229523800);
    localparam logic [DELAY_BITS-1:0]  RST_RAMP_START    = DELAY_BITS'(800000);
    localparam logic [DELAY_BITS-1:0]  RST_RAMP_STEP     = DELAY_BITS'(16000);
    localparam logic [DELAY_BITS-1:0]  RST_ON_TIME       = DELAY_BITS'(900000);

    typedef struct packed {
        logic en;
        logic load;
        logic stop;
        logic tick;
    } t_cnt_ctrl;

endpackage
`default_nettype wire

// ===== rtl/ssp_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ssp_in_if
// input channel: one beat per timer tick with optional sample and zero cross
// ----------------------------------------------------------------------------
interface ssp_in_if;
    import ssp_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   tick;
    logic                   sample_valid;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   zero_cross;

    modport source (output valid, tick, sample_valid, sample, zero_cross, input ready);
    modport sink   (input valid, tick, sample_valid, sample, zero_cross, output ready);
endinterface
`default_nettype wire

// ===== rtl/ssp_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ssp_out_if
// result channel: gate, ramp status and window results
// ----------------------------------------------------------------------------
interface ssp_out_if;
    import ssp_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  gate_enable;
    logic                  running;
    logic                  full_on;
    logic                  window_done;
    logic [SUM_BITS-1:0]   window_sum;
    logic [DELAY_BITS-1:0] firing_delay;

    modport source (output valid, gate_enable, running, full_on, window_done,
                    window_sum, firing_delay, input ready);
    modport sink   (input valid, gate_enable, running, full_on, window_done,
                    window_sum, firing_delay, output ready);
endinterface
`default_nettype wire

// ===== rtl/ssp_countdown.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ssp_countdown
// tick-driven down counter with load, stop and expiry on one or zero
// ----------------------------------------------------------------------------
module ssp_countdown (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  ssp_pkg::t_cnt_ctrl             i_ctrl,
    input  wire [ssp_pkg::DELAY_BITS-1:0]  i_load_val,
    output logic                           o_expire
);
    import ssp_pkg::*;

    logic [DELAY_BITS-1:0] r_cnt, n_cnt, cnt_a;
    logic                  r_act, n_act, act_a;

    always_comb begin
        if (i_ctrl.load) begin
            cnt_a = i_load_val;
            act_a = 1'b1;
        end else begin
            cnt_a = r_cnt;
            act_a = r_act & ~i_ctrl.stop;
        end
        o_expire = i_ctrl.tick && act_a && (cnt_a[DELAY_BITS-1:1] == '0);
        n_act    = act_a && !o_expire;
        if (!i_ctrl.tick || !act_a) begin
            n_cnt = cnt_a;
        end else if (o_expire) begin
            n_cnt = '0;
        end else begin
            n_cnt = cnt_a - DELAY_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_act <= 1'b0;
        end else if (i_ctrl.en) begin
            r_cnt <= n_cnt;
            r_act <= n_act;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/soft_start_phase_angle_controller.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// soft_start_phase_angle_controller
// Triac soft starter: mains mean-square window with hysteresis, firing delay
// ramp and zero-cross timed gate.
//
// i_in carries one beat per timer tick, with an optional ADC sample and an
// optional zero-cross edge; o_out returns exactly one result beat for each.
// i_cfg_we/i_cfg_idx/i_cfg_data write the seven settings; they are to be
// written only while idle, which the block itself does not enforce. The
// first register holds the offset-corrected square, the second the updated
// controller state and the result. One beat is taken every cycle while the
// receiver keeps up; the state update (accumulate, threshold compare, ramp
// step and counter decrement) between those two registers is combinational.
// A stalled receiver holds the result register; the square stage still takes
// one more beat, then i_in.ready drops until the result moves on.
// Reset loads the default settings, clears the window, flags, counters and
// gate, and sets the firing delay to the ramp start.
// ----------------------------------------------------------------------------
module soft_start_phase_angle_controller (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    ssp_in_if.sink                            i_in,
    ssp_out_if.source                         o_out,
    input  wire                               i_cfg_we,
    input  wire [ssp_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  wire [ssp_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);
    import ssp_pkg::*;

    // settings
    logic [SAMPLE_BITS-1:0] r_offset;
    logic [WIN_BITS-1:0]    r_window_length;
    logic [SUM_BITS-1:0]    r_on_threshold, r_off_threshold;
    logic [DELAY_BITS-1:0]  r_ramp_start, r_ramp_step, r_on_time;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset        <= RST_OFFSET;
            r_window_length <= RST_WINDOW_LENGTH;
            r_on_threshold  <= RST_ON_THRESHOLD;
            r_off_threshold <= RST_OFF_THRESHOLD;
            r_ramp_start    <= RST_RAMP_START;
            r_ramp_step     <= RST_RAMP_STEP;
            r_on_time       <= RST_ON_TIME;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_OFFSET:        r_offset        <= i_cfg_data[SAMPLE_BITS-1:0];
                CFG_WINDOW_LENGTH: r_window_length <= i_cfg_data[WIN_BITS-1:0];
                CFG_ON_THRESHOLD:  r_on_threshold  <= i_cfg_data[SUM_BITS-1:0];
                CFG_OFF_THRESHOLD: r_off_threshold <= i_cfg_data[SUM_BITS-1:0];
                CFG_RAMP_START:    r_ramp_start    <= i_cfg_data[DELAY_BITS-1:0];
                CFG_RAMP_STEP:     r_ramp_step     <= i_cfg_data[DELAY_BITS-1:0];
                CFG_ON_TIME:       r_on_time       <= i_cfg_data[DELAY_BITS-1:0];
                default: ;
            endcase
        end
    end

    // handshake
    logic r_s1_valid, r_out_valid;
    logic out_free, s1_move, in_beat;

    assign out_free   = !r_out_valid || o_out.ready;
    assign s1_move    = r_s1_valid && out_free;
    assign i_in.ready = !r_s1_valid || out_free;
    assign in_beat    = i_in.valid && i_in.ready;

    // square stage
    logic signed [SAMPLE_BITS:0]       adj;
    logic signed [SQ_BITS-1:0]         adj_wide, sq_full;
    logic [SQ_BITS-1:0]                r_s1_sq;
    logic                              r_s1_tick, r_s1_sv, r_s1_zc;

    assign adj      = $signed({1'b0, i_in.sample}) - $signed({1'b0, r_offset});
    assign adj_wide = SQ_BITS'(adj);
    assign sq_full  = adj_wide * adj_wide;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_beat) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
        if (in_beat) begin
            r_s1_sq   <= sq_full;
            r_s1_tick <= i_in.tick;
            r_s1_sv   <= i_in.sample_valid;
            r_s1_zc   <= i_in.zero_cross;
        end
    end

    // controller state
    logic [SUM_BITS-1:0]   r_acc, n_acc, r_last_sum, n_last_sum;
    logic [WIN_BITS-1:0]   r_count, n_count, count_inc;
    logic                  r_run, n_run, r_full, n_full, r_gate, n_gate, win_gate;
    logic [DELAY_BITS-1:0] r_delay, n_delay;
    logic [SUM_BITS:0]     acc_sum;
    logic [SUM_BITS-1:0]   acc_sat;
    logic                  done, cnt_stop, delay_exp, hold_exp;
    t_cnt_ctrl             delay_ctrl, hold_ctrl;

    assign acc_sum   = {1'b0, r_acc} + (SUM_BITS+1)'(r_s1_sq);
    assign acc_sat   = acc_sum[SUM_BITS] ? '1 : acc_sum[SUM_BITS-1:0];
    assign count_inc = r_count + WIN_BITS'(1);

    always_comb begin
        n_acc      = r_acc;
        n_count    = r_count;
        n_last_sum = r_last_sum;
        n_run      = r_run;
        n_full     = r_full;
        n_delay    = r_delay;
        win_gate   = r_gate;
        done       = 1'b0;
        cnt_stop   = 1'b0;
        if (r_s1_sv) begin
            n_acc   = acc_sat;
            n_count = count_inc;
            if (count_inc >= r_window_length) begin
                n_last_sum = acc_sat;
                n_acc      = '0;
                n_count    = '0;
                done       = 1'b1;
                if (acc_sat >= r_on_threshold) begin
                    n_run = 1'b1;
                end else if (acc_sat < r_off_threshold) begin
                    n_run    = 1'b0;
                    n_full   = 1'b0;
                    n_delay  = r_ramp_start;
                    win_gate = 1'b0;
                end
                if (n_run) begin
                    if (n_delay > r_ramp_step) begin
                        n_delay = n_delay - r_ramp_step;
                    end else begin
                        n_full   = 1'b1;
                        cnt_stop = 1'b1;
                        win_gate = 1'b1;
                    end
                end
            end
        end
    end

    // counter expiry after the window update
    always_comb begin
        n_gate = win_gate;
        if (delay_exp && n_run) begin
            n_gate = 1'b1;
        end
        if (hold_exp) begin
            n_gate = 1'b0;
        end
    end

    assign delay_ctrl = '{en: s1_move, load: r_s1_zc && !n_full, stop: cnt_stop,
                          tick: r_s1_tick};
    assign hold_ctrl  = delay_ctrl;

    ssp_countdown u_delay_cnt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (delay_ctrl),
        .i_load_val (n_delay),
        .o_expire   (delay_exp)
    );

    ssp_countdown u_hold_cnt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (hold_ctrl),
        .i_load_val (r_on_time),
        .o_expire   (hold_exp)
    );

    logic r_o_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_count     <= '0;
            r_last_sum  <= '0;
            r_run       <= 1'b0;
            r_full      <= 1'b0;
            r_delay     <= RST_RAMP_START;
            r_gate      <= 1'b0;
            r_out_valid <= 1'b0;
            r_o_done    <= 1'b0;
        end else begin
            if (s1_move) begin
                r_acc       <= n_acc;
                r_count     <= n_count;
                r_last_sum  <= n_last_sum;
                r_run       <= n_run;
                r_full      <= n_full;
                r_delay     <= n_delay;
                r_gate      <= n_gate;
                r_o_done    <= done;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result beat reflects the state just written
    assign o_out.valid        = r_out_valid;
    assign o_out.gate_enable  = r_gate;
    assign o_out.running      = r_run;
    assign o_out.full_on      = r_full;
    assign o_out.window_done  = r_o_done;
    assign o_out.window_sum   = r_last_sum;
    assign o_out.firing_delay = r_delay;

endmodule
`default_nettype wire

// ===== bench/soft_start_phase_angle_controller_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// soft_start_phase_angle_controller_tb
// Self-checking bench for the triac soft starter. A directed table covers
// reset, sample and register extremes, window closing, hysteresis, the ramp
// to full on and the zero-cross counters. Random phases under changing
// settings follow, built from loud, quiet, mid-level and noise stretches of
// mains samples. Result beats are compared field by field with a controller
// model or a checked row's values. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module soft_start_phase_angle_controller_tb;
    import ssp_pkg::*;

    localparam int PLAN_ROWS     = 41;
    localparam int PHASES        = 12;
    localparam int PHASE_BEATS   = 120;
    localparam int SETTLE_CYCLES = 4;

    typedef struct packed {
        logic                   tick;
        logic                   sample_valid;
        logic [SAMPLE_BITS-1:0] sample;
        logic                   zero_cross;
    } t_ctl_beat;

    typedef struct packed {
        logic                  gate_enable;
        logic                  running;
        logic                  full_on;
        logic                  window_done;
        logic [SUM_BITS-1:0]   window_sum;
        logic [DELAY_BITS-1:0] firing_delay;
    } t_ctl_result;

    typedef enum logic {ROW_BEAT, ROW_REG} t_row_kind;

    typedef struct {
        t_row_kind              kind;
        t_ctl_beat              beat;
        t_cfg_idx               reg_idx;
        logic [CFG_DATA_BITS-1:0] reg_data;
        logic                   typed;
        t_ctl_result            want;
    } t_plan_row;

    typedef enum logic [1:0] {SEG_LOUD, SEG_QUIET, SEG_MID, SEG_NOISE} t_seg_kind;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     cfg_we;
    t_cfg_idx                 cfg_idx;
    logic [CFG_DATA_BITS-1:0] cfg_data;
    logic                     sink_ready = 1'b0;
    bit                       steady = 1'b0;
    int unsigned              mismatch_count = 0;

    ssp_in_if  in_if ();
    ssp_out_if out_if ();

    assign out_if.ready = sink_ready;

    soft_start_phase_angle_controller dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // settings mirror
    logic [SAMPLE_BITS-1:0] set_offset;
    logic [WIN_BITS-1:0]    set_window;
    logic [SUM_BITS-1:0]    set_on_level;
    logic [SUM_BITS-1:0]    set_off_level;
    logic [DELAY_BITS-1:0]  set_ramp_start;
    logic [DELAY_BITS-1:0]  set_ramp_step;
    logic [DELAY_BITS-1:0]  set_on_time;

    // controller state mirror
    logic [SUM_BITS-1:0]   sq_sum;
    logic [WIN_BITS-1:0]   sample_cnt;
    logic [SUM_BITS-1:0]   held_sum;
    logic                  is_running;
    logic                  is_full;
    logic [DELAY_BITS-1:0] fire_delay;
    logic [DELAY_BITS-1:0] delay_cnt;
    logic [DELAY_BITS-1:0] hold_cnt;
    logic                  delay_live;
    logic                  hold_live;
    logic                  gate;

    t_ctl_result tick_status_q [$];
    t_ctl_result head;
    t_plan_row   plan [PLAN_ROWS];

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    always @(posedge i_clk) begin
        sink_ready <= steady || ($urandom_range(99) >= 30);
    end

    function automatic void reset_controller();
        set_offset     = RST_OFFSET;
        set_window     = RST_WINDOW_LENGTH;
        set_on_level   = RST_ON_THRESHOLD;
        set_off_level  = RST_OFF_THRESHOLD;
        set_ramp_start = RST_RAMP_START;
        set_ramp_step  = RST_RAMP_STEP;
        set_on_time    = RST_ON_TIME;
        sq_sum     = '0;
        sample_cnt = '0;
        held_sum   = '0;
        is_running = 1'b0;
        is_full    = 1'b0;
        fire_delay = RST_RAMP_START;
        delay_cnt  = '0;
        hold_cnt   = '0;
        delay_live = 1'b0;
        hold_live  = 1'b0;
        gate       = 1'b0;
    endfunction

    function automatic logic counter_expired(inout logic [DELAY_BITS-1:0] cnt,
                                             inout logic live);
        if (!live) begin
            return 1'b0;
        end
        if (cnt <= DELAY_BITS'(1)) begin
            cnt  = '0;
            live = 1'b0;
            return 1'b1;
        end
        cnt = cnt - 1'b1;
        return 1'b0;
    endfunction

    // window, then zero cross, then tick
    task automatic advance_controller(input t_ctl_beat b, output t_ctl_result r);
        int     dev;
        longint acc;
        logic   closed;
        logic   fired;
        closed = 1'b0;
        if (b.sample_valid) begin
            dev = int'(b.sample) - int'(set_offset);
            acc = longint'(sq_sum) + longint'(dev * dev);
            sq_sum = (acc > longint'(32'hFFFF_FFFF)) ? '1 : acc[31:0];
            sample_cnt = sample_cnt + 1'b1;
            if (sample_cnt >= set_window) begin
                held_sum   = sq_sum;
                sq_sum     = '0;
                sample_cnt = '0;
                closed     = 1'b1;
                if (held_sum >= set_on_level) begin
                    is_running = 1'b1;
                end else if (held_sum < set_off_level) begin
                    is_running = 1'b0;
                    is_full    = 1'b0;
                    fire_delay = set_ramp_start;
                    gate       = 1'b0;
                end
                if (is_running) begin
                    if (fire_delay > set_ramp_step) begin
                        fire_delay = fire_delay - set_ramp_step;
                    end else begin
                        is_full    = 1'b1;
                        delay_live = 1'b0;
                        hold_live  = 1'b0;
                        gate       = 1'b1;
                    end
                end
            end
        end
        if (b.zero_cross && !is_full) begin
            delay_cnt  = fire_delay;
            hold_cnt   = set_on_time;
            delay_live = 1'b1;
            hold_live  = 1'b1;
        end
        if (b.tick) begin
            fired = counter_expired(delay_cnt, delay_live);
            if (fired && is_running) begin
                gate = 1'b1;
            end
            fired = counter_expired(hold_cnt, hold_live);
            if (fired) begin
                gate = 1'b0;
            end
        end
        r = '{gate, is_running, is_full, closed, held_sum, fire_delay};
    endtask

    function automatic t_plan_row beat_row(logic tk, logic sv,
                                           logic [SAMPLE_BITS-1:0] s, logic zc);
        t_plan_row row;
        row = '{ROW_BEAT, '{tk, sv, s, zc}, CFG_OFFSET, '0, 1'b0, '0};
        return row;
    endfunction

    function automatic t_plan_row checked_row(logic tk, logic sv,
                                              logic [SAMPLE_BITS-1:0] s, logic zc,
                                              t_ctl_result want);
        t_plan_row row;
        row = '{ROW_BEAT, '{tk, sv, s, zc}, CFG_OFFSET, '0, 1'b1, want};
        return row;
    endfunction

    function automatic t_plan_row reg_row(t_cfg_idx idx, logic [CFG_DATA_BITS-1:0] data);
        t_plan_row row;
        row = '{ROW_REG, '0, idx, data, 1'b0, '0};
        return row;
    endfunction

    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (tick_status_q.size() == 0) begin
                $display("%0t: result beat with nothing expected", $time);
                mismatch_count++;
            end else begin
                head = tick_status_q.pop_front();
                check_field("gate_enable", head.gate_enable, out_if.gate_enable);
                check_field("running", head.running, out_if.running);
                check_field("full_on", head.full_on, out_if.full_on);
                check_field("window_done", head.window_done, out_if.window_done);
                check_field("window_sum", head.window_sum, out_if.window_sum);
                check_field("firing_delay", head.firing_delay, out_if.firing_delay);
            end
        end
    end

    task automatic send_beat(input t_ctl_beat b, input logic typed, input t_ctl_result want);
        t_ctl_result predicted;
        while (!steady && $urandom_range(99) < 30) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.tick         <= b.tick;
        in_if.sample_valid <= b.sample_valid;
        in_if.sample       <= b.sample;
        in_if.zero_cross   <= b.zero_cross;
        @(posedge i_clk);
        while (!in_if.ready) begin
            @(posedge i_clk);
        end
        advance_controller(b, predicted);
        if (typed) begin
            predicted = want;
        end
        tick_status_q.push_back(predicted);
    endtask

    task automatic drain_results();
        in_if.valid <= 1'b0;
        while (tick_status_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_BITS-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_OFFSET:        set_offset     = data[SAMPLE_BITS-1:0];
            CFG_WINDOW_LENGTH: set_window     = data[WIN_BITS-1:0];
            CFG_ON_THRESHOLD:  set_on_level   = data[SUM_BITS-1:0];
            CFG_OFF_THRESHOLD: set_off_level  = data[SUM_BITS-1:0];
            CFG_RAMP_START:    set_ramp_start = data[DELAY_BITS-1:0];
            CFG_RAMP_STEP:     set_ramp_step  = data[DELAY_BITS-1:0];
            CFG_ON_TIME:       set_on_time    = data[DELAY_BITS-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    initial begin
        #4_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        t_ctl_beat              beat;
        t_seg_kind              seg;
        int                     seg_left;
        int                     zc_count;
        int                     zc_gap;
        int                     pick;
        int                     amp;
        int                     level;
        int                     wl;
        logic [SAMPLE_BITS-1:0] p_offset;
        logic [WIN_BITS-1:0]    p_window;
        logic [SUM_BITS-1:0]    p_on;
        logic [SUM_BITS-1:0]    p_off;
        logic [DELAY_BITS-1:0]  p_start;
        logic [DELAY_BITS-1:0]  p_step;
        logic [DELAY_BITS-1:0]  p_hold;

        i_rst_n            <= 1'b0;
        in_if.valid        <= 1'b0;
        in_if.tick         <= 1'b0;
        in_if.sample_valid <= 1'b0;
        in_if.sample       <= '0;
        in_if.zero_cross   <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_idx            <= CFG_OFFSET;
        cfg_data           <= '0;
        reset_controller();

        plan = '{
            checked_row(1'b0, 1'b0, 12'd0, 1'b0, '{1'b0, 1'b0, 1'b0, 1'b0, 32'd0, RST_RAMP_START}),
            checked_row(1'b1, 1'b1, 12'd4095, 1'b1,
                        '{1'b0, 1'b0, 1'b0, 1'b0, 32'd0, RST_RAMP_START}),
            checked_row(1'b0, 1'b1, 12'd0, 1'b0, '{1'b0, 1'b0, 1'b0, 1'b0, 32'd0, RST_RAMP_START}),
            // window length lowered below the current count
            reg_row(CFG_WINDOW_LENGTH, 32'd1),
            beat_row(1'b1, 1'b1, 12'd2048, 1'b0),
            reg_row(CFG_OFFSET, 32'd2048),
            reg_row(CFG_ON_THRESHOLD, 32'd1_000_000),
            reg_row(CFG_OFF_THRESHOLD, 32'd250_000),
            reg_row(CFG_RAMP_START, 32'd3),
            reg_row(CFG_RAMP_STEP, 32'd1),
            reg_row(CFG_ON_TIME, 32'd5),
            // stop, start, ramp, zero cross restart, full on
            beat_row(1'b0, 1'b1, 12'd2048, 1'b0),
            beat_row(1'b0, 1'b1, 12'd3048, 1'b0),
            beat_row(1'b1, 1'b0, 12'd0, 1'b1),
            beat_row(1'b1, 1'b0, 12'd0, 1'b0),
            beat_row(1'b0, 1'b0, 12'd0, 1'b1),
            beat_row(1'b1, 1'b0, 12'd0, 1'b0),
            beat_row(1'b1, 1'b1, 12'd3048, 1'b0),
            beat_row(1'b1, 1'b1, 12'd4095, 1'b1),
            beat_row(1'b1, 1'b0, 12'd0, 1'b1),
            beat_row(1'b0, 1'b1, 12'd0, 1'b0),
            beat_row(1'b1, 1'b1, 12'd2048, 1'b0),
            // overlapping thresholds, both counters expiring together
            reg_row(CFG_RAMP_START, 32'd1),
            reg_row(CFG_RAMP_STEP, 32'd0),
            reg_row(CFG_ON_TIME, 32'd1),
            reg_row(CFG_ON_THRESHOLD, 32'd100),
            reg_row(CFG_OFF_THRESHOLD, 32'd200_000),
            beat_row(1'b0, 1'b1, 12'd2048, 1'b0),
            beat_row(1'b0, 1'b1, 12'd2148, 1'b0),
            beat_row(1'b1, 1'b0, 12'd0, 1'b1),
            // zero delay, maximum thresholds
            reg_row(CFG_RAMP_START, 32'd0),
            reg_row(CFG_ON_THRESHOLD, 32'hFFFF_FFFF),
            reg_row(CFG_OFF_THRESHOLD, 32'hFFFF_FFFF),
            beat_row(1'b0, 1'b1, 12'd4095, 1'b0),
            beat_row(1'b1, 1'b0, 12'd0, 1'b1),
            // zero window length, offset extremes
            reg_row(CFG_WINDOW_LENGTH, 32'd0),
            beat_row(1'b1, 1'b1, 12'd4095, 1'b0),
            reg_row(CFG_OFFSET, 32'd4095),
            beat_row(1'b0, 1'b1, 12'd0, 1'b0),
            reg_row(CFG_OFFSET, 32'd0),
            beat_row(1'b1, 1'b1, 12'd4095, 1'b1)
        };

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[n]) begin
            if (plan[n].kind == ROW_REG) begin
                drain_results();
                write_reg(plan[n].reg_idx, plan[n].reg_data);
            end else begin
                send_beat(plan[n].beat, plan[n].typed, plan[n].want);
            end
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            drain_results();
            case (phase)
                0: begin
                    p_offset = '1;
                    p_window = '1;
                    p_on     = '1;
                    p_off    = '1;
                    p_start  = '1;
                    p_step   = '1;
                    p_hold   = '1;
                end
                1: begin
                    p_offset = '0;
                    p_window = '0;
                    p_on     = '0;
                    p_off    = '0;
                    p_start  = '0;
                    p_step   = '0;
                    p_hold   = '0;
                end
                2: begin
                    p_offset = RST_OFFSET;
                    p_window = RST_WINDOW_LENGTH;
                    p_on     = RST_ON_THRESHOLD;
                    p_off    = RST_OFF_THRESHOLD;
                    p_start  = RST_RAMP_START;
                    p_step   = RST_RAMP_STEP;
                    p_hold   = RST_ON_TIME;
                end
                default: begin
                    p_offset = ($urandom_range(7) == 0) ? SAMPLE_BITS'($urandom_range(4095))
                                                        : SAMPLE_BITS'($urandom_range(3072, 1024));
                    p_window = ($urandom_range(7) == 0) ? WIN_BITS'($urandom_range(255))
                                                        : WIN_BITS'($urandom_range(6, 1));
                    wl = (p_window == 0) ? 1 : int'(p_window);
                    if ($urandom_range(7) == 0) begin
                        p_on  = $urandom;
                        p_off = $urandom;
                    end else begin
                        p_on  = SUM_BITS'(wl * 250_000);
                        p_off = SUM_BITS'(wl * 100_000);
                    end
                    p_start = DELAY_BITS'($urandom_range(20));
                    p_step  = DELAY_BITS'($urandom_range(8, 2));
                    p_hold  = ($urandom_range(7) == 0) ? DELAY_BITS'($urandom_range(1048575))
                                                       : DELAY_BITS'($urandom_range(30));
                end
            endcase
            write_reg(CFG_OFFSET, CFG_DATA_BITS'(p_offset));
            write_reg(CFG_WINDOW_LENGTH, CFG_DATA_BITS'(p_window));
            write_reg(CFG_ON_THRESHOLD, p_on);
            write_reg(CFG_OFF_THRESHOLD, p_off);
            write_reg(CFG_RAMP_START, CFG_DATA_BITS'(p_start));
            write_reg(CFG_RAMP_STEP, CFG_DATA_BITS'(p_step));
            write_reg(CFG_ON_TIME, CFG_DATA_BITS'(p_hold));
            steady   = (phase == 3);
            seg      = SEG_LOUD;
            seg_left = 0;
            zc_count = 0;
            zc_gap   = 12;

            for (int k = 0; k < PHASE_BEATS; k++) begin
                if (seg_left == 0) begin
                    pick = $urandom_range(99);
                    seg  = (pick < 45) ? SEG_LOUD : (pick < 70) ? SEG_QUIET :
                           (pick < 80) ? SEG_MID : SEG_NOISE;
                    seg_left = $urandom_range(60, 10);
                end
                seg_left--;
                if (seg == SEG_NOISE) begin
                    beat.tick         = 1'($urandom_range(1));
                    beat.sample_valid = 1'($urandom_range(1));
                    beat.sample       = SAMPLE_BITS'($urandom_range(4095));
                    beat.zero_cross   = 1'($urandom_range(1));
                end else begin
                    case (seg)
                        SEG_LOUD:  amp = $urandom_range(1000, 600);
                        SEG_QUIET: amp = $urandom_range(150);
                        default:   amp = $urandom_range(450, 350);
                    endcase
                    level = int'(p_offset) + ($urandom_range(1) ? amp : -amp);
                    if (level < 0) begin
                        level = 0;
                    end else if (level > 4095) begin
                        level = 4095;
                    end
                    // mains half-cycle edges
                    zc_count++;
                    beat.zero_cross = (zc_count >= zc_gap);
                    if (beat.zero_cross) begin
                        zc_count = 0;
                        zc_gap   = $urandom_range(16, 6);
                    end
                    beat.tick         = ($urandom_range(99) < 90);
                    beat.sample_valid = ($urandom_range(99) < 70);
                    beat.sample       = SAMPLE_BITS'(level);
                end
                send_beat(beat, 1'b0, '0);
            end
        end

        drain_results();
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
